@@ design/usi_pkg.sv @@
// Shared types, register codes and constants of the ultrasonic safety interlock.
// Used by usi_echo_filter, usi_interlock and the top level; depends on nothing.
package usi_pkg;

	localparam int ECHO_BITS_DEF = 16;
	localparam int DIST_W        = 14;
	localparam logic [DIST_W-1:0] DIST_MAX = 14'd16383;

	localparam logic KIND_ECHO = 1'b0;
	localparam logic KIND_CMD  = 1'b1;

	typedef enum logic [2:0] {
		REG_STOP_DIST     = 3'd0,
		REG_RELEASE_DIST  = 3'd1,
		REG_STOP_COUNT    = 3'd2,
		REG_RELEASE_COUNT = 3'd3,
		REG_TIMEOUT       = 3'd4,
		REG_ECHO_MIN      = 3'd5,
		REG_ECHO_MAX      = 3'd6,
		REG_EMA_ALPHA     = 3'd7
	} cfg_reg_t;

	typedef struct packed {
		logic [15:0] stop_distance_cm;
		logic [15:0] release_distance_cm;
		logic [7:0]  stop_count_needed;
		logic [7:0]  release_count_needed;
		logic [31:0] echo_age_limit_ms;
		logic [15:0] echo_min_us;
		logic [15:0] echo_max_us;
		logic [15:0] ema_alpha;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		stop_distance_cm:     16'd30,
		release_distance_cm:  16'd40,
		stop_count_needed:    8'd3,
		release_count_needed: 8'd3,
		echo_age_limit_ms:    32'd200,
		echo_min_us:          16'd120,
		echo_max_us:          16'd25000,
		ema_alpha:            16'd0
	};

	// Item after range gate and distance conversion.
	typedef struct packed {
		logic               kind;
		logic [31:0]        now_ms;
		logic               acc;
		logic [DIST_W-1:0]  tenths;
		logic signed [15:0] left_cmd;
		logic signed [15:0] right_cmd;
	} conv_t;

	// Result item.
	typedef struct packed {
		logic               echo_accepted;
		logic signed [15:0] left_drive;
		logic signed [15:0] right_drive;
		logic               stopped;
		logic [DIST_W-1:0]  distance_tenths;
	} res_t;

	// us*10/58 saturates to DIST_MAX from this echo width on.
	localparam logic [16:0] MED_SAT     = 17'd95028;
	// 5 * ceil(2^24 / 29): us*10/58 = (us*5)/29, exact below MED_SAT.
	localparam logic [21:0] DIV58_MUL   = 22'd2892625;
	localparam int          DIV58_SHIFT = 24;
	// ceil(2^17 / 10): exact division by ten for any 14-bit value.
	localparam logic [13:0] DIV10_MUL   = 14'd13108;
	localparam int          DIV10_SHIFT = 17;

endpackage

@@ design/ultrasonic_safety_interlock.sv @@
// Ultrasonic safety interlock: echo items update a median-filtered, optionally smoothed
// distance; command items pass motor drives, zeroed while in emergency stop. Items go from
// the input register through the echo stage and the safety stage to the result; one item is
// accepted every cycle while results are taken, as each stage updates its per-item state
// (history ring in the echo stage, EMA and hysteresis in the safety stage) as the item
// leaves it. Configuration is written through cfg_valid/cfg_index/cfg_data while idle; the user
// must keep to this, as the block does not enforce it. Depends on usi_pkg, usi_echo_filter and usi_interlock.
module ultrasonic_safety_interlock #(
	parameter int ECHO_BITS = usi_pkg::ECHO_BITS_DEF
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     s_tvalid,
	output logic                                     s_tready,
	// now_ms[31:0], echo_us[ECHO_BITS], left_cmd[16], right_cmd[16], zero fill
	input  logic [((64+ECHO_BITS+7)/8)*8-1:0]        s_tdata,
	// kind
	input  logic                                     s_tuser,
	output logic                                     m_tvalid,
	input  logic                                     m_tready,
	// left_drive[15:0], right_drive[31:16], stopped[32], distance_tenths[46:33], zero[47]
	output logic [47:0]                              m_tdata,
	// echo_accepted
	output logic                                     m_tuser,
	input  logic                                     cfg_valid,
	output logic                                     cfg_ready,
	input  logic [2:0]                               cfg_index,
	input  logic [31:0]                              cfg_data
);
	import usi_pkg::*;

	cfg_t cfg_q;

	logic                 v1_q, v2_q, v3_q;
	logic                 en1, en2, en3;
	logic                 kind_s1;
	logic [31:0]          now_s1;
	logic [ECHO_BITS-1:0] echo_s1;
	logic signed [15:0]   left_s1, right_s1;
	conv_t                conv_s2;
	res_t                 res_s3;

	assign en3      = !v3_q || m_tready;
	assign en2      = !v2_q || en3;
	assign en1      = !v1_q || en2;
	assign s_tready = en1;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_STOP_DIST:     cfg_q.stop_distance_cm     <= cfg_data[15:0];
				REG_RELEASE_DIST:  cfg_q.release_distance_cm  <= cfg_data[15:0];
				REG_STOP_COUNT:    cfg_q.stop_count_needed    <= cfg_data[7:0];
				REG_RELEASE_COUNT: cfg_q.release_count_needed <= cfg_data[7:0];
				REG_TIMEOUT:       cfg_q.echo_age_limit_ms    <= cfg_data;
				REG_ECHO_MIN:      cfg_q.echo_min_us          <= cfg_data[15:0];
				REG_ECHO_MAX:      cfg_q.echo_max_us          <= cfg_data[15:0];
				REG_EMA_ALPHA:     cfg_q.ema_alpha            <= cfg_data[15:0];
				default:           cfg_q                      <= cfg_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
			v2_q <= 1'b0;
			v3_q <= 1'b0;
		end else begin
			if (en1) v1_q <= s_tvalid;
			if (en2) v2_q <= v1_q;
			if (en3) v3_q <= v2_q;
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			kind_s1  <= s_tuser;
			now_s1   <= s_tdata[31:0];
			echo_s1  <= s_tdata[32 +: ECHO_BITS];
			left_s1  <= s_tdata[32+ECHO_BITS +: 16];
			right_s1 <= s_tdata[48+ECHO_BITS +: 16];
		end
	end

	usi_echo_filter #(
		.ECHO_BITS(ECHO_BITS)
	) u_echo (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.adv      (en2),
		.take     (v1_q && en2),
		.in_kind  (kind_s1),
		.in_now   (now_s1),
		.in_echo  (echo_s1),
		.in_left  (left_s1),
		.in_right (right_s1),
		.conv_s2  (conv_s2)
	);

	usi_interlock u_lock (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.adv    (en3),
		.take   (v2_q && en3),
		.conv   (conv_s2),
		.res_s3 (res_s3)
	);

	assign m_tvalid = v3_q;
	assign m_tuser  = res_s3.echo_accepted;
	assign m_tdata  = {1'b0, res_s3.distance_tenths, res_s3.stopped,
		res_s3.right_drive, res_s3.left_drive};

	a_stop_zeroes_drives: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[32] |-> m_tdata[31:0] == 32'd0)
		else $error("drive passed while stopped");

	a_echo_no_drive: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata[31:0] == 32'd0)
		else $error("accepted echo carries a drive");

	a_stall_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> v1_q && v2_q && v3_q && !m_tready)
		else $error("input stalled with room in the pipeline");

endmodule

@@ design/usi_echo_filter.sv @@
// Echo stage: range gate, three-entry history ring, median and conversion to tenths of cm.
// Depends on usi_pkg.
module usi_echo_filter #(
	parameter int ECHO_BITS = usi_pkg::ECHO_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  usi_pkg::cfg_t         cfg,
	input  logic                  adv,
	input  logic                  take,
	input  logic                  in_kind,
	input  logic [31:0]           in_now,
	input  logic [ECHO_BITS-1:0]  in_echo,
	input  logic signed [15:0]    in_left,
	input  logic signed [15:0]    in_right,
	output usi_pkg::conv_t        conv_s2
);
	import usi_pkg::*;

	logic [ECHO_BITS-1:0] hist_q [3];
	logic [1:0]           slot_q;
	logic [1:0]           fill_q;

	logic [ECHO_BITS-1:0] hist_n [3];
	logic [ECHO_BITS-1:0] lo_ab, hi_ab, mid_hc, med;
	logic [32:0]          us_ext, med_ext;
	logic                 gate_ok, sat;
	logic [38:0]          prod;
	logic [DIST_W-1:0]    tenths;

	always_comb begin
		us_ext  = {{(33-ECHO_BITS){1'b0}}, in_echo};
		gate_ok = (in_kind == KIND_ECHO) &&
			!(us_ext < {17'd0, cfg.echo_min_us} || us_ext > {17'd0, cfg.echo_max_us});
		for (int i = 0; i < 3; i++) begin
			hist_n[i] = (slot_q == 2'(i)) ? in_echo : hist_q[i];
		end
		lo_ab  = (hist_n[0] < hist_n[1]) ? hist_n[0] : hist_n[1];
		hi_ab  = (hist_n[0] < hist_n[1]) ? hist_n[1] : hist_n[0];
		mid_hc = (hi_ab < hist_n[2]) ? hi_ab : hist_n[2];
		// The raw echo is used until the ring has been filled once.
		med     = (fill_q < 2'd3) ? in_echo : ((lo_ab > mid_hc) ? lo_ab : mid_hc);
		med_ext = {{(33-ECHO_BITS){1'b0}}, med};
		sat     = med_ext >= {16'd0, MED_SAT};
		prod    = 39'(med_ext[16:0]) * 39'(DIV58_MUL);
		tenths  = sat ? DIST_MAX : prod[DIV58_SHIFT +: DIST_W];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q <= 2'd0;
			fill_q <= 2'd0;
		end else if (take && gate_ok) begin
			slot_q <= (slot_q == 2'd2) ? 2'd0 : slot_q + 2'd1;
			if (fill_q < 2'd3) begin
				fill_q <= fill_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && gate_ok) begin
			for (int i = 0; i < 3; i++) begin
				hist_q[i] <= hist_n[i];
			end
		end
		if (adv) begin
			conv_s2.kind      <= in_kind;
			conv_s2.now_ms    <= in_now;
			conv_s2.acc       <= gate_ok;
			conv_s2.tenths    <= tenths;
			conv_s2.left_cmd  <= in_left;
			conv_s2.right_cmd <= in_right;
		end
	end

endmodule

@@ design/usi_interlock.sv @@
// Safety stage: optional EMA smoothing, echo age check, stop/release hysteresis, drive gating.
// Depends on usi_pkg; holds the result register.
module usi_interlock (
	input  logic           clk,
	input  logic           arst_n,
	input  usi_pkg::cfg_t  cfg,
	input  logic           adv,
	input  logic           take,
	input  usi_pkg::conv_t conv,
	output usi_pkg::res_t  res_s3
);
	import usi_pkg::*;

	logic              stop_q, measured_q;
	logic [7:0]        near_q, far_q;
	logic [DIST_W-1:0] dist_q, smooth_q;
	logic [31:0]       last_ms_q;

	logic              stop_n, measured_n;
	logic [7:0]        near_n, far_n, cnt_inc;
	logic [DIST_W-1:0] dist_n, smooth_n, ema_out;
	logic [31:0]       last_ms_n, elapsed;
	logic signed [14:0] diff;
	logic signed [31:0] ema_prod;
	logic signed [17:0] ema_sum;
	logic [27:0]       cm_prod;
	logic [10:0]       cm;
	logic              apply;
	res_t              res_n;

	always_comb begin
		diff     = 15'(signed'({1'b0, conv.tenths}) - signed'({1'b0, smooth_q}));
		ema_prod = 32'(diff) * signed'({16'd0, cfg.ema_alpha});
		// Arithmetic shift floors the step toward minus infinity.
		ema_sum  = signed'({4'd0, smooth_q}) + 18'(ema_prod >>> 15);
		if (ema_sum < 0) begin
			ema_out = '0;
		end else if (ema_sum > signed'({4'd0, DIST_MAX})) begin
			ema_out = DIST_MAX;
		end else begin
			ema_out = ema_sum[DIST_W-1:0];
		end

		cm_prod = 28'(dist_q) * 28'(DIV10_MUL);
		cm      = cm_prod[DIV10_SHIFT +: 11];
		elapsed = conv.now_ms - last_ms_q;
		apply   = take;

		stop_n     = stop_q;
		near_n     = near_q;
		far_n      = far_q;
		dist_n     = dist_q;
		smooth_n   = smooth_q;
		last_ms_n  = last_ms_q;
		measured_n = measured_q;
		cnt_inc    = '0;

		res_n.echo_accepted = 1'b0;
		res_n.left_drive    = '0;
		res_n.right_drive   = '0;

		if (conv.kind == KIND_ECHO) begin
			if (conv.acc) begin
				if (cfg.ema_alpha != 16'd0) begin
					smooth_n = measured_q ? ema_out : conv.tenths;
					dist_n   = smooth_n;
				end else begin
					dist_n = conv.tenths;
				end
				last_ms_n           = conv.now_ms;
				measured_n          = 1'b1;
				res_n.echo_accepted = 1'b1;
			end
		end else begin
			if (!measured_q || elapsed > cfg.echo_age_limit_ms) begin
				stop_n = 1'b1;
				near_n = '0;
				far_n  = '0;
			end
			// The hysteresis still runs after a timeout stop, so a release can follow at once.
			if (measured_q) begin
				if (!stop_n) begin
					if ({5'd0, cm} <= cfg.stop_distance_cm) begin
						cnt_inc = (near_n == 8'hFF) ? near_n : near_n + 8'd1;
						if (cnt_inc >= cfg.stop_count_needed) begin
							stop_n = 1'b1;
							near_n = '0;
							far_n  = '0;
						end else begin
							near_n = cnt_inc;
						end
					end else begin
						near_n = '0;
					end
				end else begin
					if ({5'd0, cm} >= cfg.release_distance_cm) begin
						cnt_inc = (far_n == 8'hFF) ? far_n : far_n + 8'd1;
						if (cnt_inc >= cfg.release_count_needed) begin
							stop_n = 1'b0;
							near_n = '0;
							far_n  = '0;
						end else begin
							far_n = cnt_inc;
						end
					end else begin
						far_n = '0;
					end
				end
			end
			if (!stop_n) begin
				res_n.left_drive  = conv.left_cmd;
				res_n.right_drive = conv.right_cmd;
			end
		end
		res_n.stopped         = stop_n;
		res_n.distance_tenths = dist_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stop_q     <= 1'b0;
			near_q     <= '0;
			far_q      <= '0;
			dist_q     <= '0;
			smooth_q   <= '0;
			last_ms_q  <= '0;
			measured_q <= 1'b0;
		end else if (apply) begin
			stop_q     <= stop_n;
			near_q     <= near_n;
			far_q      <= far_n;
			dist_q     <= dist_n;
			smooth_q   <= smooth_n;
			last_ms_q  <= last_ms_n;
			measured_q <= measured_n;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_s3 <= res_n;
		end
	end

endmodule

@@ verif/tb_top.sv @@
// Self-checking testbench of ultrasonic_safety_interlock: a scoreboard class predicts every
// result from the accepted requests, and plain tasks drive the stream and register ports.
// Depends on usi_pkg and the ultrasonic_safety_interlock RTL.
`timescale 1ns / 100ps

module tb_top;
	import usi_pkg::*;

	localparam int IN_W        = ((64 + ECHO_BITS_DEF + 7) / 8) * 8;
	localparam int CYCLE_LIMIT = 200000;
	localparam int PHASE_ITEMS = 67;
	localparam int HOLD_CYCLES = 400;

	class interlock_scoreboard;
		cfg_t        cfg;
		logic        stop_mode;
		logic [7:0]  near_cnt, far_cnt;
		logic [15:0] ring [3];
		logic [1:0]  fill, slot;
		logic [13:0] distance, smoothed;
		logic [31:0] last_ms;
		logic        measured;
		res_t        expected_q[$];
		int          errors;

		function new();
			cfg = CFG_RESET;
			stop_mode = 0;
			near_cnt = 0;
			far_cnt = 0;
			ring = '{16'd0, 16'd0, 16'd0};
			fill = 0;
			slot = 0;
			distance = 0;
			smoothed = 0;
			last_ms = 0;
			measured = 0;
			errors = 0;
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		function void write_reg(cfg_reg_t idx, logic [31:0] val);
			case (idx)
				REG_STOP_DIST:     cfg.stop_distance_cm = val[15:0];
				REG_RELEASE_DIST:  cfg.release_distance_cm = val[15:0];
				REG_STOP_COUNT:    cfg.stop_count_needed = val[7:0];
				REG_RELEASE_COUNT: cfg.release_count_needed = val[7:0];
				REG_TIMEOUT:       cfg.echo_age_limit_ms = val;
				REG_ECHO_MIN:      cfg.echo_min_us = val[15:0];
				REG_ECHO_MAX:      cfg.echo_max_us = val[15:0];
				REG_EMA_ALPHA:     cfg.ema_alpha = val[15:0];
				default: ;
			endcase
		endfunction

		// Works out the result of one accepted request and queues it.
		function void note_input(logic kind, logic [31:0] now_ms, logic [15:0] echo_us,
				logic [15:0] left_cmd, logic [15:0] right_cmd);
			res_t        want;
			logic [15:0] a, b, c, t, med;
			logic [31:0] tenths;
			longint      prod, blend;
			int          cm;
			want = '0;
			if (kind == KIND_ECHO) begin
				if (echo_us >= cfg.echo_min_us && echo_us <= cfg.echo_max_us) begin
					ring[slot] = echo_us;
					slot = (slot == 2'd2) ? 2'd0 : slot + 2'd1;
					if (fill < 2'd3) begin
						fill++;
						med = echo_us;
					end else begin
						a = ring[0];
						b = ring[1];
						c = ring[2];
						if (a > b) begin t = a; a = b; b = t; end
						if (b > c) begin t = b; b = c; c = t; end
						if (a > b) begin t = a; a = b; b = t; end
						med = b;
					end
					tenths = (32'(med) * 32'd10) / 32'd58;
					if (tenths > 32'(DIST_MAX))
						tenths = 32'(DIST_MAX);
					if (cfg.ema_alpha != 0) begin
						if (!measured) begin
							smoothed = tenths[13:0];
						end else begin
							// The shift floors, also for a negative step.
							prod = (longint'(tenths) - longint'(smoothed)) * longint'(cfg.ema_alpha);
							blend = longint'(smoothed) + (prod >>> 15);
							if (blend < 0)
								blend = 0;
							if (blend > longint'(DIST_MAX))
								blend = longint'(DIST_MAX);
							smoothed = blend[13:0];
						end
						distance = smoothed;
					end else begin
						distance = tenths[13:0];
					end
					last_ms = now_ms;
					measured = 1;
					want.echo_accepted = 1;
				end
			end else begin
				want.left_drive = left_cmd;
				want.right_drive = right_cmd;
				if (!measured || (now_ms - last_ms) > cfg.echo_age_limit_ms) begin
					stop_mode = 1;
					near_cnt = 0;
					far_cnt = 0;
				end
				// Hysteresis runs even right after a forced stop.
				if (measured) begin
					cm = int'(distance) / 10;
					if (!stop_mode) begin
						if (cm <= int'(cfg.stop_distance_cm)) begin
							if (near_cnt != 8'hFF)
								near_cnt++;
							if (near_cnt >= cfg.stop_count_needed) begin
								stop_mode = 1;
								near_cnt = 0;
								far_cnt = 0;
							end
						end else begin
							near_cnt = 0;
						end
					end else begin
						if (cm >= int'(cfg.release_distance_cm)) begin
							if (far_cnt != 8'hFF)
								far_cnt++;
							if (far_cnt >= cfg.release_count_needed) begin
								stop_mode = 0;
								near_cnt = 0;
								far_cnt = 0;
							end
						end else begin
							far_cnt = 0;
						end
					end
				end
				if (stop_mode) begin
					want.left_drive = 0;
					want.right_drive = 0;
				end
			end
			want.stopped = stop_mode;
			want.distance_tenths = distance;
			expected_q.push_back(want);
		endfunction

		function void report(string field, logic signed [31:0] want, logic signed [31:0] seen);
			errors++;
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, seen);
		endfunction

		function void check_result(res_t got);
			res_t want;
			if (expected_q.size() == 0) begin
				errors++;
				$display("%0t: result with nothing expected, got %h", $time, got);
				return;
			end
			want = expected_q.pop_front();
			if (got.echo_accepted !== want.echo_accepted)
				report("echo_accepted", 32'(want.echo_accepted), 32'(got.echo_accepted));
			if (got.left_drive !== want.left_drive)
				report("left_drive", 32'(want.left_drive), 32'(got.left_drive));
			if (got.right_drive !== want.right_drive)
				report("right_drive", 32'(want.right_drive), 32'(got.right_drive));
			if (got.stopped !== want.stopped)
				report("stopped", 32'(want.stopped), 32'(got.stopped));
			if (got.distance_tenths !== want.distance_tenths)
				report("distance_tenths", 32'(want.distance_tenths),
					32'(got.distance_tenths));
		endfunction
	endclass

	logic            clk = 1'b0;
	logic            arst_n = 1'b0;
	logic            s_tvalid = 1'b0;
	logic            s_tready;
	logic [IN_W-1:0] s_tdata = '0;
	logic            s_tuser = 1'b0;
	logic            m_tvalid;
	logic            m_tready = 1'b0;
	logic [47:0]     m_tdata;
	logic            m_tuser;
	logic            cfg_valid = 1'b0;
	logic            cfg_ready;
	cfg_reg_t        cfg_index = REG_STOP_DIST;
	logic [31:0]     cfg_data = '0;

	interlock_scoreboard sb;
	int          send_idle_pct = 34;
	int          recv_idle_pct = 69;
	logic        stall_request = 1'b0;
	int          stall_left = 0;
	int          cycles = 0;
	logic [31:0] clock_ms = '0;
	int          zone = 0;

	ultrasonic_safety_interlock u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #1 clk = ~clk;

	function automatic logic [15:0] rnd16();
		return 16'($urandom);
	endfunction

	// Result side: random back-pressure, plus a long hold-off on request.
	always @(posedge clk) begin : result_side
		res_t got;
		if (arst_n && m_tvalid && m_tready) begin
			got.echo_accepted = m_tuser;
			got.left_drive = m_tdata[15:0];
			got.right_drive = m_tdata[31:16];
			got.stopped = m_tdata[32];
			got.distance_tenths = m_tdata[46:33];
			sb.check_result(got);
		end
		if (stall_request) begin
			stall_request = 1'b0;
			stall_left = HOLD_CYCLES;
		end
		if (stall_left > 0) begin
			stall_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	initial begin
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("Some tests failed");
		$finish;
	end

	// Offers one request; valid stays high after acceptance unless the next call idles.
	task automatic send_item(logic kind, logic [31:0] now_ms, logic [15:0] echo_us,
			logic [15:0] left_cmd, logic [15:0] right_cmd);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= kind;
		s_tdata <= {right_cmd, left_cmd, echo_us, now_ms};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		sb.note_input(kind, now_ms, echo_us, left_cmd, right_cmd);
	endtask

	task automatic write_all(cfg_t c);
		logic [31:0] val;
		int          i;
		for (i = 0; i < 8; i++) begin
			case (cfg_reg_t'(i))
				REG_STOP_DIST:     val = 32'(c.stop_distance_cm);
				REG_RELEASE_DIST:  val = 32'(c.release_distance_cm);
				REG_STOP_COUNT:    val = 32'(c.stop_count_needed);
				REG_RELEASE_COUNT: val = 32'(c.release_count_needed);
				REG_TIMEOUT:       val = c.echo_age_limit_ms;
				REG_ECHO_MIN:      val = 32'(c.echo_min_us);
				REG_ECHO_MAX:      val = 32'(c.echo_max_us);
				default:           val = 32'(c.ema_alpha);
			endcase
			cfg_valid <= 1'b1;
			cfg_index <= cfg_reg_t'(i);
			cfg_data <= val;
			@(posedge clk);
			while (!cfg_ready)
				@(posedge clk);
			sb.write_reg(cfg_reg_t'(i), val);
		end
		cfg_valid <= 1'b0;
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	// Mostly echoes that dwell near the stop or release distance, so the counts
	// run up; commands use a slowly advancing clock with rare large jumps.
	task automatic run_phase(int count);
		int k, roll, cm, v;
		for (k = 0; k < count; k++) begin
			roll = $urandom_range(0, 99);
			v = $urandom_range(0, 99);
			if (v < 70)
				clock_ms += $urandom_range(0, 30);
			else if (v < 95)
				clock_ms += $urandom_range(0, 400);
			else
				clock_ms += $urandom;
			if (roll < 5) begin
				send_item(1'($urandom_range(0, 1)), $urandom, rnd16(), rnd16(), rnd16());
			end else if (roll < 60) begin
				if ($urandom_range(0, 99) < 25)
					zone = $urandom_range(0, 4);
				case (zone)
					0: cm = int'(sb.cfg.stop_distance_cm) - $urandom_range(0, 3);
					1: cm = int'(sb.cfg.release_distance_cm) + $urandom_range(0, 3);
					2: cm = (int'(sb.cfg.stop_distance_cm) + int'(sb.cfg.release_distance_cm)) / 2;
					3: cm = $urandom_range(0, 1130);
					default: cm = -1;
				endcase
				if (cm < 0)
					v = $urandom_range(0, 65535);
				else
					v = cm * 58 + $urandom_range(0, 57);
				if (v > 65535)
					v = 65535;
				send_item(KIND_ECHO, clock_ms, 16'(v), rnd16(), rnd16());
			end else begin
				send_item(KIND_CMD, clock_ms, rnd16(), rnd16(), rnd16());
			end
		end
	endtask

	initial begin : stimulus
		cfg_t c;
		int   mode, p;
		sb = new();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Reset settings: no echo yet, gate edges, the timeout boundary, median start-up.
		send_item(KIND_CMD, 32'd0, rnd16(), 16'h7FFF, 16'h8000);
		send_item(KIND_ECHO, 32'd5, 16'd119, rnd16(), rnd16());
		send_item(KIND_ECHO, 32'd6, 16'd25001, rnd16(), rnd16());
		send_item(KIND_ECHO, 32'd10, 16'd120, rnd16(), rnd16());
		send_item(KIND_CMD, 32'd210, rnd16(), 16'h1234, 16'hEDCB);
		send_item(KIND_CMD, 32'd211, rnd16(), 16'h1234, 16'hEDCB);
		send_item(KIND_ECHO, 32'd300, 16'd25000, rnd16(), rnd16());
		send_item(KIND_ECHO, 32'd301, 16'd24000, rnd16(), rnd16());
		send_item(KIND_ECHO, 32'd302, 16'd23000, rnd16(), rnd16());
		repeat (3) send_item(KIND_CMD, 32'd303, rnd16(), 16'hFFFF, 16'h0001);
		send_item(KIND_ECHO, 32'd304, 16'h0000, rnd16(), rnd16());
		send_item(KIND_ECHO, 32'd305, 16'hFFFF, rnd16(), rnd16());
		drain();

		// Open gate, zero counts, overshooting smoothing weight, clock wrap.
		c = CFG_RESET;
		c.stop_distance_cm = 16'd0;
		c.release_distance_cm = 16'hFFFF;
		c.stop_count_needed = 8'd0;
		c.release_count_needed = 8'd0;
		c.echo_age_limit_ms = 32'hFFFF_FFFF;
		c.echo_min_us = 16'd0;
		c.echo_max_us = 16'hFFFF;
		c.ema_alpha = 16'hFFFF;
		write_all(c);
		send_item(KIND_ECHO, 32'hFFFF_FFF0, 16'h0000, rnd16(), rnd16());
		send_item(KIND_ECHO, 32'hFFFF_FFFF, 16'hFFFF, rnd16(), rnd16());
		send_item(KIND_CMD, 32'h0000_0010, rnd16(), 16'h0100, 16'hFF00);
		send_item(KIND_ECHO, 32'h0000_0011, 16'd1000, rnd16(), rnd16());
		send_item(KIND_CMD, 32'h0000_0011, rnd16(), 16'h0100, 16'hFF00);
		drain();

		// Crossed gate; a stale command releases again on the same request.
		c.echo_age_limit_ms = 32'd0;
		c.echo_min_us = 16'd200;
		c.echo_max_us = 16'd100;
		c.release_distance_cm = 16'd0;
		c.ema_alpha = 16'd1;
		write_all(c);
		send_item(KIND_ECHO, 32'h0000_0012, 16'd150, rnd16(), rnd16());
		send_item(KIND_CMD, 32'h0000_0011, rnd16(), 16'h5555, 16'hAAAA);
		send_item(KIND_CMD, 32'h0000_0012, rnd16(), 16'h5555, 16'hAAAA);
		drain();

		clock_ms = 32'hFFFF_FC00;
		for (mode = 0; mode < 3; mode++) begin
			send_idle_pct = (mode == 0) ? 34 : (mode == 1) ? 69 : 0;
			recv_idle_pct = (mode == 0) ? 69 : (mode == 1) ? 34 : 0;
			for (p = 0; p < 8; p++) begin
				c.stop_distance_cm = 16'($urandom_range(0, 120));
				c.release_distance_cm = 16'(c.stop_distance_cm + $urandom_range(0, 40));
				c.stop_count_needed = 8'($urandom_range(0, 5));
				c.release_count_needed = 8'($urandom_range(0, 5));
				c.echo_age_limit_ms = $urandom_range(0, 500);
				c.echo_min_us = 16'($urandom_range(0, 500));
				c.echo_max_us = 16'($urandom_range(2000, 65535));
				case ($urandom_range(0, 3))
					0: c.ema_alpha = 16'd0;
					1: c.ema_alpha = 16'($urandom_range(1, 32768));
					2: c.ema_alpha = 16'd32768;
					default: c.ema_alpha = 16'($urandom_range(32769, 65535));
				endcase
				case (p)
					0: begin
						c = '{16'hFFFF, 16'hFFFF, 8'd0, 8'd0, 32'hFFFF_FFFF,
							16'd0, 16'hFFFF, 16'hFFFF};
					end
					1: begin
						c = '{16'd0, 16'd0, 8'hFF, 8'hFF, 32'd0, 16'hFFFF, 16'd0, 16'd1};
					end
					2: begin
						c = '{16'd0, 16'd0, 8'd0, 8'd0, 32'hFFFF_FFFF,
							16'd0, 16'hFFFF, 16'd32768};
					end
					default: ;
				endcase
				write_all(c);
				// With no idling on either side, hold the results back so the input stalls.
				if (mode == 2 && p == 3)
					stall_request = 1'b1;
				run_phase(PHASE_ITEMS);
				drain();
			end
		end

		if (sb.errors == 0 && sb.pending() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
